// ----- design/ccpa_pkg.sv -----
// Shared codes, widths and types for the chain code polygon area block.
package ccpa_pkg;

    localparam int ACC_WIDTH   = 49;
    localparam int WHOLE_WIDTH = 46;

    localparam logic [7:0] CODE_SW   = 8'h31;
    localparam logic [7:0] CODE_S    = 8'h32;
    localparam logic [7:0] CODE_SE   = 8'h33;
    localparam logic [7:0] CODE_W    = 8'h34;
    localparam logic [7:0] CODE_END  = 8'h35;
    localparam logic [7:0] CODE_E    = 8'h36;
    localparam logic [7:0] CODE_NW   = 8'h37;
    localparam logic [7:0] CODE_N    = 8'h38;
    localparam logic [7:0] CODE_NE   = 8'h39;

    typedef struct packed {
        logic               is_move;
        logic               is_term;
        logic signed [1:0]  dx;
        logic signed [1:0]  dy;
    } step_t;

endpackage

// ----- design/ccpa_decode.sv -----
// Decodes one direction code into a unit step and its control bits.
module ccpa_decode
    import ccpa_pkg::*;
(
    input  logic [7:0] code,
    output step_t      step
);

    always_comb
    begin
        step.is_move = 1'b1;
        step.is_term = 1'b0;
        step.dx      = 2'sd0;
        step.dy      = 2'sd0;
        case (code)
            CODE_SW:
            begin
                step.dx = -2'sd1;
                step.dy = -2'sd1;
            end
            CODE_S:
            begin
                step.dy = -2'sd1;
            end
            CODE_SE:
            begin
                step.dx = 2'sd1;
                step.dy = -2'sd1;
            end
            CODE_W:
            begin
                step.dx = -2'sd1;
            end
            CODE_E:
            begin
                step.dx = 2'sd1;
            end
            CODE_NW:
            begin
                step.dx = -2'sd1;
                step.dy = 2'sd1;
            end
            CODE_N:
            begin
                step.dy = 2'sd1;
            end
            CODE_NE:
            begin
                step.dx = 2'sd1;
                step.dy = 2'sd1;
            end
            CODE_END:
            begin
                step.is_move = 1'b0;
                step.is_term = 1'b1;
            end
            default:
            begin
                step.is_move = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/ccpa_datapath.sv -----
// Position, twice-area accumulator and range flag, with the area magnitude.
module ccpa_datapath
    import ccpa_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  step_t                   step,
    output logic [WHOLE_WIDTH-1:0]  area_whole,
    output logic                    area_half,
    output logic                    overflow
);

    localparam int TERM_WIDTH = COORD_WIDTH + 2;

    logic [COORD_WIDTH-1:0]  pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0]  pos_y_reg, pos_y_next;
    logic [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic                    err_reg, err_next;

    logic signed [TERM_WIDTH-1:0] ext_x, ext_y, part_x, part_y, term;
    logic [COORD_WIDTH:0]         nx_wide, ny_wide;
    logic [ACC_WIDTH-1:0]         mag;

    assign ext_x = {{2{pos_x_reg[COORD_WIDTH-1]}}, pos_x_reg};
    assign ext_y = {{2{pos_y_reg[COORD_WIDTH-1]}}, pos_y_reg};

    // Cross term x*dy - dx*y with unit steps reduces to adds and subtracts.
    always_comb
    begin
        case (step.dy)
            2'sd1:   part_x = ext_x;
            -2'sd1:  part_x = -ext_x;
            default: part_x = '0;
        endcase
        case (step.dx)
            2'sd1:   part_y = ext_y;
            -2'sd1:  part_y = -ext_y;
            default: part_y = '0;
        endcase
        term = part_x - part_y;
    end

    assign nx_wide = {pos_x_reg[COORD_WIDTH-1], pos_x_reg}
                     + {{(COORD_WIDTH-1){step.dx[1]}}, step.dx};
    assign ny_wide = {pos_y_reg[COORD_WIDTH-1], pos_y_reg}
                     + {{(COORD_WIDTH-1){step.dy[1]}}, step.dy};

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        if (fire && step.is_term)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            acc_next   = '0;
            err_next   = 1'b0;
        end
        else if (fire && step.is_move)
        begin
            pos_x_next = nx_wide[COORD_WIDTH-1:0];
            pos_y_next = ny_wide[COORD_WIDTH-1:0];
            acc_next   = acc_reg
                         + {{(ACC_WIDTH-TERM_WIDTH){term[TERM_WIDTH-1]}}, term};
            // A carry out of the sign bit means the coordinate left its range.
            err_next   = err_reg
                         | (nx_wide[COORD_WIDTH] ^ nx_wide[COORD_WIDTH-1])
                         | (ny_wide[COORD_WIDTH] ^ ny_wide[COORD_WIDTH-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    assign mag        = acc_reg[ACC_WIDTH-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign area_whole = mag[WHOLE_WIDTH:1];
    assign area_half  = mag[0];
    assign overflow   = err_reg;

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step.is_term) |=>
            (pos_x_reg == '0 && pos_y_reg == '0 && acc_reg == '0 && !err_reg))
        else $error("state not cleared after terminator");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && (step.is_move || step.is_term)) |=>
            ($stable(acc_reg) && $stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("state changed without a move or terminator");

    a_err_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(err_reg) |-> $past(fire && step.is_move))
        else $error("range flag set without a move");

endmodule

// ----- design/chain_code_polygon_area.sv -----
// Top level of the chain code polygon area block.
//
// Input channel: one 8-bit direction word per handshake (in_valid, in_stall).
// Keypad digits 1-4 and 6-9 move the lattice position one step; digit 5
// closes the polygon; every other code is dropped without effect.
// Output channel: one word per closed polygon (out_valid, out_stall) holding
// the absolute area as whole part plus half flag, and an overflow flag that
// is set when a coordinate left its signed COORD_WIDTH range on that path.
// Throughput is one word per cycle unless a terminator is held: the input
// register feeds the step logic and the accumulator updates in the same cycle,
// so a move held in the input register never waits. A terminator accepted into
// the input register is consumed from it once the result register is free;
// that consume loads the result register and raises out_valid.
// While out_stall holds a result, moves keep flowing; a second terminator
// waits in the input register, and only then is in_stall raised.
// Reset clears position, accumulator, overflow flag and both valid bits.
module chain_code_polygon_area
    import ccpa_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              code,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [WHOLE_WIDTH-1:0]  area_whole,
    output logic                    area_half,
    output logic                    overflow
);

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              code_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [WHOLE_WIDTH-1:0]  whole_reg;
    logic                    half_reg;
    logic                    ovf_reg;

    step_t                   step;
    logic                    out_free;
    logic                    consume;
    logic                    accept;
    logic                    load_out;
    logic [WHOLE_WIDTH-1:0]  whole_c;
    logic                    half_c;
    logic                    ovf_c;

    ccpa_decode u_decode
    (
        .code (code_reg),
        .step (step)
    );

    ccpa_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (consume),
        .step       (step),
        .area_whole (whole_c),
        .area_half  (half_c),
        .overflow   (ovf_c)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // Only a terminator needs room in the result register.
    assign consume  = in_valid_reg && (!step.is_term || out_free);
    assign in_stall = in_valid_reg && !consume;
    assign accept   = in_valid && !in_stall;
    assign load_out = consume && step.is_term;

    assign in_valid_next  = accept || (in_valid_reg && !consume);
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= code;
        end
        if (load_out)
        begin
            whole_reg <= whole_c;
            half_reg  <= half_c;
            ovf_reg   <= ovf_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign area_whole = whole_reg;
    assign area_half  = half_reg;
    assign overflow   = ovf_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && step.is_term))
        else $error("input stalled without a held terminator");

    a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_stall && step.is_term) |=> out_valid)
        else $error("terminator consumed but no result");

    a_blocked_term: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && in_valid_reg && step.is_term) |-> in_stall)
        else $error("terminator consumed while result register busy");

endmodule
